// ===== design/mvm_pkg.sv =====
// Shared constants and types for the matrix-vector multiply block.
`default_nettype none

package mvm_pkg;

    // Default sizes for the top-level parameters.
    localparam int VEC_MAX_DEF    = 1024;
    localparam int ROWS_MAX_DEF   = 4096;
    localparam int DATA_WIDTH_DEF = 16;

    // Fixed field and datapath widths.
    localparam int ACC_W      = 48;
    localparam int FRAC_SHIFT = 8;
    localparam int ROW_IDX_W  = 12;
    localparam int VEC_LEN_W  = 11;
    localparam int ROW_CNT_W  = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // Entries in the result queue, which is also the number of row results
    // that may be outstanding at once.
    localparam int RES_Q_DEPTH = 4;
    localparam int RES_Q_PTR_W = $clog2(RES_Q_DEPTH);
    localparam int RES_Q_CNT_W = $clog2(RES_Q_DEPTH + 1);

    typedef enum logic [0:0] {
        OP_LOAD   = 1'b0,
        OP_WEIGHT = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VEC_LEN   = 1'b0,
        CFG_ROW_COUNT = 1'b1
    } cfg_idx_t;

endpackage

`default_nettype wire

// ===== design/mvm_result_fifo.sv =====
// Small register queue that holds finished row results until they are taken.
`default_nettype none

module mvm_result_fifo
    import mvm_pkg::*;
#(
    parameter int WIDTH = 30
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0]       entry_reg [RES_Q_DEPTH];
    logic [RES_Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_Q_CNT_W-1:0] count_reg, count_next;
    logic                   pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/matrix_vector_multiply.sv =====
// Top level of the streaming fixed-point matrix-vector multiply-accumulate block.
//
//  Channel   Direction  Handshake           Contents
//  s_        in         s_tvalid/s_tready   load or weight item, one per transfer
//  m_        out        m_tvalid/m_tready   one row result per transfer
//  cfg_      in         cfg_valid/cfg_ready register write (index, data)
//
// The block takes one item per cycle while s_tready is high. A row result is
// valid on m_ once the row's final weight has passed the stages in order: the
// vector memory read beside the registered weight, the registered product, the
// registered row sum; the shifted, saturated sum is then written into the result
// queue. The input side stalls only while four row results are outstanding,
// which is the depth of the result queue; the output may be held off for any
// time without loss. Reset is synchronous on aresetn low; it clears the positions,
// the accumulator and the queue, and loads vec_len = 1024 and row_count = 1.
// The vector memory is not cleared: entries must be loaded before use.
`default_nettype none

module matrix_vector_multiply
    import mvm_pkg::*;
#(
    parameter int VEC_MAX    = VEC_MAX_DEF,
    parameter int ROWS_MAX   = ROWS_MAX_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int IN_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((DATA_WIDTH + ROW_IDX_W + 7) / 8) * 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // value
    input  wire logic                   s_tuser,   // opcode

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_TDATA_W-1:0] m_tdata,   // result, row_index
    output logic                        m_tuser,   // saturated
    output logic                        m_tlast,   // last row of the pass

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int DW      = DATA_WIDTH;
    localparam int POS_W   = $clog2(VEC_MAX);
    localparam int LEN_W   = $clog2(VEC_MAX + 1);
    localparam int ROW_W   = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
    localparam int RCNT_W  = $clog2(ROWS_MAX + 1);
    localparam int RX_W    = (ROW_W > ROW_IDX_W) ? ROW_W : ROW_IDX_W;
    localparam int PROD_W  = 2 * DW;
    localparam int EXT_W   = (PROD_W > ACC_W) ? PROD_W : ACC_W;
    localparam int SH_W    = ACC_W - FRAC_SHIFT;
    localparam int LEN_RST = (VEC_MAX < 1024) ? VEC_MAX : 1024;
    localparam int RES_W   = DW + ROW_IDX_W + 2;

    // ------------------------------------------------------------------
    // Configuration. The effective lengths are clamped when written, so
    // the datapath only ever sees legal values.
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [RCNT_W-1:0] rows_reg, rows_next;
    logic              cfg_xfer;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    always_comb begin
        len_next  = len_reg;
        rows_next = rows_reg;
        if (cfg_xfer && cfg_index == CFG_VEC_LEN) begin
            if (cfg_data[VEC_LEN_W-1:0] == '0) begin
                len_next = LEN_W'(1);
            end else if (32'(cfg_data[VEC_LEN_W-1:0]) > VEC_MAX) begin
                len_next = LEN_W'(VEC_MAX);
            end else begin
                len_next = LEN_W'(cfg_data[VEC_LEN_W-1:0]);
            end
        end
        if (cfg_xfer && cfg_index == CFG_ROW_COUNT) begin
            if (cfg_data[ROW_CNT_W-1:0] == '0) begin
                rows_next = RCNT_W'(1);
            end else if (32'(cfg_data[ROW_CNT_W-1:0]) > ROWS_MAX) begin
                rows_next = RCNT_W'(ROWS_MAX);
            end else begin
                rows_next = RCNT_W'(cfg_data[ROW_CNT_W-1:0]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Accept stage: position bookkeeping and the vector memory access.
    // A load writes the memory; a weight reads the element of its column.
    // Positions at or beyond a shortened length count as zero.
    // ------------------------------------------------------------------
    logic [DW-1:0]     vec_mem [VEC_MAX];
    logic [DW-1:0]     rd_data_reg;

    logic [POS_W-1:0]  ld_pos_reg, ld_pos_next;
    logic [POS_W-1:0]  col_pos_reg, col_pos_next;
    logic [ROW_W-1:0]  row_pos_reg, row_pos_next;
    logic [RES_Q_CNT_W-1:0] pend_reg, pend_next;

    logic              in_xfer, ld_xfer, wt_xfer;
    logic [DW-1:0]     in_value;
    logic [POS_W-1:0]  ld_cur, col_cur;
    logic [ROW_W-1:0]  row_cur;
    logic [LEN_W-1:0]  ld_inc, col_inc;
    logic [RCNT_W-1:0] row_inc;
    logic              row_end, pass_last, out_xfer;

    assign s_tready = (pend_reg < RES_Q_CNT_W'(RES_Q_DEPTH));
    assign in_xfer  = s_tvalid && s_tready;
    assign ld_xfer  = in_xfer && (op_t'(s_tuser) == OP_LOAD);
    assign wt_xfer  = in_xfer && (op_t'(s_tuser) == OP_WEIGHT);
    assign in_value = s_tdata[DW-1:0];
    assign out_xfer = m_tvalid && m_tready;

    always_comb begin
        ld_cur  = (LEN_W'(ld_pos_reg) >= len_reg) ? '0 : ld_pos_reg;
        col_cur = (LEN_W'(col_pos_reg) >= len_reg) ? '0 : col_pos_reg;
        row_cur = (RCNT_W'(row_pos_reg) >= rows_reg) ? '0 : row_pos_reg;
        ld_inc  = LEN_W'(ld_cur) + 1'b1;
        col_inc = LEN_W'(col_cur) + 1'b1;
        row_inc = RCNT_W'(row_cur) + 1'b1;
        row_end   = (col_inc >= len_reg);
        pass_last = (row_inc >= rows_reg);

        ld_pos_next  = ld_pos_reg;
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (ld_xfer) begin
            ld_pos_next = (ld_inc >= len_reg) ? '0 : ld_inc[POS_W-1:0];
        end
        if (wt_xfer) begin
            col_pos_next = row_end ? '0 : col_inc[POS_W-1:0];
            if (row_end) begin
                row_pos_next = pass_last ? '0 : row_inc[ROW_W-1:0];
            end else begin
                row_pos_next = row_cur;
            end
        end

        // Row results accepted but not yet taken from the output.
        pend_next = pend_reg;
        if ((wt_xfer && row_end) && !out_xfer) begin
            pend_next = pend_reg + 1'b1;
        end else if (out_xfer && !(wt_xfer && row_end)) begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_xfer) begin
            vec_mem[ld_cur] <= in_value;
        end
        if (wt_xfer) begin
            rd_data_reg <= vec_mem[col_cur];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline: stage 1 holds the weight beside the memory read data,
    // stage 2 the product, stage 3 the finished row sum.
    // ------------------------------------------------------------------
    logic              p1_valid_reg, p1_end_reg, p1_last_reg;
    logic [DW-1:0]     p1_w_reg;
    logic [ROW_W-1:0]  p1_row_reg;

    logic              p2_valid_reg, p2_end_reg, p2_last_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [ROW_W-1:0]  p2_row_reg;

    logic              p3_valid_reg, p3_last_reg;
    logic [ACC_W-1:0]  sum_reg;
    logic [ROW_W-1:0]  p3_row_reg;

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [EXT_W-1:0] prod_ext;
    logic [ACC_W-1:0]  acc_sum;

    assign prod_ext = EXT_W'(prod_reg);
    assign acc_sum  = acc_reg + prod_ext[ACC_W-1:0];

    always_comb begin
        acc_next = acc_reg;
        if (p2_valid_reg) begin
            acc_next = p2_end_reg ? '0 : acc_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= LEN_W'(LEN_RST);
            rows_reg     <= RCNT_W'(1);
            ld_pos_reg   <= '0;
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            pend_reg     <= '0;
            acc_reg      <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else begin
            len_reg      <= len_next;
            rows_reg     <= rows_next;
            ld_pos_reg   <= ld_pos_next;
            col_pos_reg  <= col_pos_next;
            row_pos_reg  <= row_pos_next;
            pend_reg     <= pend_next;
            acc_reg      <= acc_next;
            p1_valid_reg <= wt_xfer;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg && p2_end_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wt_xfer) begin
            p1_w_reg    <= in_value;
            p1_end_reg  <= row_end;
            p1_last_reg <= pass_last;
            p1_row_reg  <= row_cur;
        end
        if (p1_valid_reg) begin
            prod_reg    <= $signed(p1_w_reg) * $signed(rd_data_reg);
            p2_end_reg  <= p1_end_reg;
            p2_last_reg <= p1_last_reg;
            p2_row_reg  <= p1_row_reg;
        end
        if (p2_valid_reg && p2_end_reg) begin
            sum_reg     <= acc_sum;
            p3_last_reg <= p2_last_reg;
            p3_row_reg  <= p2_row_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: arithmetic shift out the extra fraction bits, then clip to
    // the signed data range. The result fits when all bits from the data
    // sign bit upward agree.
    // ------------------------------------------------------------------
    logic [SH_W-1:0]     shifted;
    logic [SH_W-DW:0]    top_bits;
    logic                sat;
    logic [DW-1:0]       clipped;
    logic [RX_W-1:0]     row_ext;
    logic [RES_W-1:0]    res_push_data, res_out_data;

    assign shifted  = sum_reg[ACC_W-1:FRAC_SHIFT];
    assign top_bits = shifted[SH_W-1:DW-1];
    assign sat      = !((&top_bits) || (~|top_bits));
    assign row_ext  = RX_W'(p3_row_reg);

    always_comb begin
        if (!sat) begin
            clipped = shifted[DW-1:0];
        end else if (shifted[SH_W-1]) begin
            clipped = {1'b1, {(DW-1){1'b0}}};
        end else begin
            clipped = {1'b0, {(DW-1){1'b1}}};
        end
    end

    assign res_push_data = {p3_last_reg, sat, row_ext[ROW_IDX_W-1:0], clipped};

    mvm_result_fifo #(
        .WIDTH(RES_W)
    ) u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (p3_valid_reg),
        .push_data (res_push_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_out_data)
    );

    assign m_tdata = OUT_TDATA_W'(res_out_data[DW+ROW_IDX_W-1:0]);
    assign m_tuser = res_out_data[DW+ROW_IDX_W];
    assign m_tlast = res_out_data[DW+ROW_IDX_W+1];

endmodule

`default_nettype wire
